### rtl/bsd_pkg.sv
// bsd_pkg: shared types and constants for the bounded stack with dump
// no dependencies; used by the interfaces and imported by every rtl module
`default_nettype none

package bsd_pkg;

  // storage geometry
  localparam int DEPTH  = 64;
  localparam int AW     = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int DATA_W = 32;

  // capacity register
  localparam int               CAP_W     = 7;
  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  // operation codes
  typedef enum logic [1:0] {
    OP_PUSH      = 2'd0,
    OP_POP       = 2'd1,
    OP_DUMP_DOWN = 2'd2,
    OP_DUMP_UP   = 2'd3
  } op_t;

  // controller states
  typedef enum logic {
    ST_IDLE,
    ST_SEND
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic push;
    logic pop;
    logic dump_start;
    logic dump_up;
    logic dump_next;
  } dp_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic full;
    logic empty;
    logic last;
  } dp_status_t;

endpackage

`default_nettype wire

### rtl/bsd_if.sv
// bsd_if: valid/ready channel interfaces for operations, dump results and config
// depends on bsd_pkg for field widths
`default_nettype none

// operation channel
interface bsd_in_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 op;
  logic [bsd_pkg::DATA_W-1:0] push_value;

  modport source (output valid, output op, output push_value, input ready);
  modport sink (input valid, input op, input push_value, output ready);
endinterface

// dump result channel
interface bsd_out_if;
  logic                       valid;
  logic                       ready;
  logic [bsd_pkg::DATA_W-1:0] entry_value;
  logic                       is_last;

  modport source (output valid, output entry_value, output is_last, input ready);
  modport sink (input valid, input entry_value, input is_last, output ready);
endinterface

// capacity write channel
interface bsd_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [bsd_pkg::CAP_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

### rtl/bounded_stack_with_dump_top.sv
// bounded_stack_with_dump_top: lifo stack of signed 32-bit values with dump runs
// depends on bsd_pkg, bsd_if, bsd_ctrl and bsd_dp
//
// usage
//   req  : operation channel (op, push_value). push stores unless full, pop drops
//          the top unless empty, dump down / dump up emit every stored entry.
//   rsp  : one transfer per dumped entry, is_last set on the final one.
//   cfg  : capacity write, always ready; the user must write it only while the
//          block is idle; the block itself does not enforce this.
//   push and pop can follow back to back.
//   a dump of n entries returns its first entry in the cycle after the request
//   transfers, from the registered memory read, and then one entry per cycle
//   while rsp.ready is high; req is held off until the last entry transfers.
// reset
//   rst clears the stack to empty and sets the capacity to 64; entry contents
//   are not cleared and no clearing pass is needed.
// stalls
//   while rsp.ready is low the current entry holds and the walk pauses.
`default_nettype none

module bounded_stack_with_dump_top (
  input  wire logic clk,
  input  wire logic rst,
  bsd_in_if.sink    req,
  bsd_out_if.source rsp,
  bsd_cfg_if.sink   cfg
);
  import bsd_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;
  logic       in_ready;
  logic       out_valid;
  logic [DATA_W-1:0] entry_value;
  logic       is_last;

  // capacity writes are always taken
  assign cfg.ready = 1'b1;

  // controller
  bsd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .op        (op_t'(req.op)),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (rsp.ready),
    .cmd       (cmd),
    .status    (status)
  );

  // datapath
  bsd_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .push_value  (req.push_value),
    .cfg_valid   (cfg.valid),
    .cfg_data    (cfg.data),
    .status      (status),
    .entry_value (entry_value),
    .is_last     (is_last)
  );

  assign req.ready       = in_ready;
  assign rsp.valid       = out_valid;
  assign rsp.entry_value = entry_value;
  assign rsp.is_last     = is_last;

  // no new operation is taken while a dump entry is pending
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(req.ready && rsp.valid))
    else $error("operation accepted during a dump run");

  // the final dump transfer returns the block to idle
  a_last_ends_run: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.ready && rsp.is_last) |=> (req.ready && !rsp.valid))
    else $error("dump run did not end after its last entry");

  // push and pop never produce a result
  a_push_pop_silent: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready && (req.op == OP_PUSH || req.op == OP_POP))
      |=> !rsp.valid)
    else $error("push or pop produced a result");

endmodule

`default_nettype wire

### rtl/bsd_ctrl.sv
// bsd_ctrl: controller state machine, decodes operations and paces dump runs
// depends on bsd_pkg
`default_nettype none

module bsd_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  input  wire bsd_pkg::op_t        op,
  output logic                     in_ready,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output bsd_pkg::dp_cmd_t         cmd,
  input  wire bsd_pkg::dp_status_t status
);
  import bsd_pkg::*;

  state_t state;
  state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (op)
            OP_PUSH: begin
              cmd.push = !status.full;
            end
            OP_POP: begin
              cmd.pop = !status.empty;
            end
            OP_DUMP_DOWN, OP_DUMP_UP: begin
              // empty stack dumps nothing
              if (!status.empty) begin
                cmd.dump_start = 1'b1;
                cmd.dump_up    = (op == OP_DUMP_UP);
                state_next     = ST_SEND;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_SEND: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (status.last) begin
            state_next = ST_IDLE;
          end else begin
            cmd.dump_next = 1'b1;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### rtl/bsd_dp.sv
// bsd_dp: datapath with entry memory, fill count, capacity register and dump walker
// depends on bsd_pkg
`default_nettype none

module bsd_dp (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire bsd_pkg::dp_cmd_t           cmd,
  input  wire logic [bsd_pkg::DATA_W-1:0] push_value,
  input  wire logic                       cfg_valid,
  input  wire logic [bsd_pkg::CAP_W-1:0]  cfg_data,
  output bsd_pkg::dp_status_t             status,
  output logic [bsd_pkg::DATA_W-1:0]      entry_value,
  output logic                            is_last
);
  import bsd_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [CNT_W-1:0]  count;
  logic [CAP_W-1:0]  capacity;
  logic [AW-1:0]     idx;
  logic              dir_up;

  logic [CAP_W-1:0]  eff_cap;
  logic              rd_en;
  logic              rd_up;
  logic [AW-1:0]     rd_idx;
  logic [CNT_W-1:0]  down_addr;
  logic [AW-1:0]     rd_addr;
  logic              rd_last;

  // capacity saturates at the storage depth
  assign eff_cap = (capacity > CAP_W'(DEPTH)) ? CAP_W'(DEPTH) : capacity;

  assign status.full  = (CAP_W'(count) >= eff_cap);
  assign status.empty = (count == '0);
  assign status.last  = is_last;

  // dump read address: first entry on start, next one on each transfer
  assign rd_en     = cmd.dump_start | cmd.dump_next;
  assign rd_up     = cmd.dump_start ? cmd.dump_up : dir_up;
  assign rd_idx    = cmd.dump_start ? '0 : AW'(idx + AW'(1));
  assign down_addr = CNT_W'(count - CNT_W'(1) - CNT_W'(rd_idx));
  assign rd_addr   = rd_up ? rd_idx : down_addr[AW-1:0];
  assign rd_last   = (CNT_W'(rd_idx) == CNT_W'(count - CNT_W'(1)));

  // entry memory, registered read
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[count[AW-1:0]] <= push_value;
    end
    if (rd_en) begin
      entry_value <= mem[rd_addr];
    end
  end

  // dump walker position, direction and last mark
  always_ff @(posedge clk) begin
    if (rd_en) begin
      idx     <= rd_idx;
      dir_up  <= rd_up;
      is_last <= rd_last;
    end
  end

  // fill count and capacity
  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      capacity <= CAP_RESET;
    end else begin
      if (cmd.push) begin
        count <= CNT_W'(count + CNT_W'(1));
      end else if (cmd.pop) begin
        count <= CNT_W'(count - CNT_W'(1));
      end
      if (cfg_valid) begin
        capacity <= cfg_data;
      end
    end
  end

endmodule

`default_nettype wire

### dv/tb_bounded_stack_with_dump_top.sv
`timescale 1ns / 1ps
// tb_bounded_stack_with_dump_top: self-checking bench for the bounded lifo stack with dump
// a queue-fed driver and a checking monitor run against a local stack model
// depends on bsd_pkg, bsd_if and the rtl under rtl/

module tb_bounded_stack_with_dump_top;
  import bsd_pkg::*;

  localparam int HALF_PERIOD   = 6;
  localparam int RESET_CYCLES  = 6;
  localparam int SETTLE_CYCLES = 4;
  localparam int LONG_HOLD     = 300;
  localparam int IDLE_LIMIT    = 3000;
  localparam int PHASE_OPS     = 42;
  localparam int FILL_PUSHES   = 70;
  localparam int REPORT_LIMIT  = 40;

  localparam logic [DATA_W-1:0] VAL_MIN  = 32'h8000_0000;
  localparam logic [DATA_W-1:0] VAL_MAX  = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] VAL_ONES = 32'hFFFF_FFFF;

  typedef struct {
    op_t               op;
    logic [DATA_W-1:0] value;
  } stack_op_t;

  typedef struct {
    logic [DATA_W-1:0] value;
    logic              is_last;
  } dump_entry_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  bsd_in_if  req_if ();
  bsd_out_if rsp_if ();
  bsd_cfg_if cfg_if ();

  bounded_stack_with_dump_top u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if),
    .cfg (cfg_if)
  );

  // clock
  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  // local stack model
  logic [DATA_W-1:0] model_mem [DEPTH];
  int unsigned       model_count;
  logic [CAP_W-1:0]  model_cap;

  stack_op_t   op_queue [$];
  dump_entry_t dump_expect_q [$];

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  logic        long_hold_req  = 1'b0;
  int          hold_left;
  int          idle_cycles;
  int          err_count      = 0;
  int          ops_queued     = 0;
  int          ops_accepted   = 0;
  int          entries_seen   = 0;
  int          cap_writes     = 0;
  int unsigned longest_dump   = 0;

  // apply one accepted operation to the model, queue the dump entries it yields
  function automatic void model_apply(op_t op, logic [DATA_W-1:0] value);
    int unsigned limit;
    limit = (model_cap > DEPTH) ? DEPTH : model_cap;
    case (op)
      OP_PUSH: begin
        if (model_count < limit) begin
          model_mem[model_count] = value;
          model_count++;
        end
      end
      OP_POP: begin
        if (model_count > 0) model_count--;
      end
      OP_DUMP_DOWN: begin
        for (int k = 0; k < model_count; k++)
          dump_expect_q.push_back('{value: model_mem[model_count - 1 - k],
                                    is_last: (k + 1 == model_count)});
      end
      default: begin
        for (int k = 0; k < model_count; k++)
          dump_expect_q.push_back('{value: model_mem[k], is_last: (k + 1 == model_count)});
      end
    endcase
    if (op inside {OP_DUMP_DOWN, OP_DUMP_UP} && model_count > longest_dump)
      longest_dump = model_count;
  endfunction

  task automatic report_mismatch(string what, logic [DATA_W-1:0] got,
                                 logic [DATA_W-1:0] want);
    err_count++;
    if (err_count <= REPORT_LIMIT)
      $display("[%0t] mismatch: %s got %0d want %0d", $time, what, $signed(got),
               $signed(want));
  endtask

  // driver: offer queued ops, model each one on its transfer
  always @(posedge clk) begin
    stack_op_t next_op;
    logic      holding;
    holding = req_if.valid && !req_if.ready;
    if (rst) begin
      req_if.valid <= 1'b0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        model_apply(op_t'(req_if.op), req_if.push_value);
        ops_accepted++;
      end
      if (!holding) begin
        if (op_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          next_op = op_queue.pop_front();
          req_if.op         <= next_op.op;
          req_if.push_value <= next_op.value;
          req_if.valid      <= 1'b1;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // monitor: check each dump transfer against the oldest expected entry
  always @(posedge clk) begin
    dump_entry_t want;
    if (rst) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        entries_seen++;
        if (dump_expect_q.size() == 0) begin
          report_mismatch("unexpected dump entry", rsp_if.entry_value, '0);
        end else begin
          want = dump_expect_q.pop_front();
          if (rsp_if.entry_value !== want.value)
            report_mismatch("entry_value", rsp_if.entry_value, want.value);
          if (rsp_if.is_last !== want.is_last)
            report_mismatch("is_last", DATA_W'(rsp_if.is_last), DATA_W'(want.is_last));
        end
      end
      rsp_if.ready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // long output hold, counted here once armed
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (long_hold_req) begin
      hold_left <= LONG_HOLD;
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("[%0t] watchdog: no transfer for %0d cycles", $time, IDLE_LIMIT);
      $display("FAILED: results differ");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic [DATA_W-1:0] random_value();
    case ($urandom_range(0, 9))
      0:       return VAL_MIN;
      1:       return VAL_MAX;
      2:       return '0;
      3:       return VAL_ONES;
      default: return $urandom;
    endcase
  endfunction

  // mostly pushes and pops, with a dump now and then
  function automatic stack_op_t random_op();
    stack_op_t   item;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 48)      item.op = OP_PUSH;
    else if (pick < 78) item.op = OP_POP;
    else if (pick < 89) item.op = OP_DUMP_DOWN;
    else                item.op = OP_DUMP_UP;
    item.value = random_value();
    return item;
  endfunction

  task automatic queue_op(op_t op, logic [DATA_W-1:0] value);
    op_queue.push_back('{op: op, value: value});
    ops_queued++;
  endtask

  task automatic queue_random_ops(int unsigned n);
    stack_op_t item;
    repeat (n) begin
      item = random_op();
      queue_op(item.op, item.value);
    end
  endtask

  // wait for every queued op to transfer and every dump entry to arrive
  task automatic wait_drained();
    do @(posedge clk);
    while (ops_accepted != ops_queued || dump_expect_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(logic [CAP_W-1:0] cap);
    @(posedge clk);
    cfg_if.data  <= cap;
    cfg_if.valid <= 1'b1;
    do @(posedge clk);
    while (!cfg_if.ready);
    model_cap = cap;
    cap_writes++;
    cfg_if.valid <= 1'b0;
  endtask

  // random phase, with a full drain halfway through
  task automatic run_phase(int unsigned idle_pct, int unsigned stall_pct,
                           logic [CAP_W-1:0] cap);
    write_capacity(cap);
    send_idle_pct  <= idle_pct;
    recv_stall_pct <= stall_pct;
    queue_random_ops(PHASE_OPS / 2);
    wait_drained();
    queue_random_ops(PHASE_OPS - PHASE_OPS / 2);
    wait_drained();
  endtask

  initial begin
    req_if.valid      = 1'b0;
    req_if.op         = OP_PUSH;
    req_if.push_value = '0;
    rsp_if.ready      = 1'b0;
    cfg_if.valid      = 1'b0;
    cfg_if.data       = '0;
    model_count       = 0;
    model_cap         = CAP_RESET;

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // empty stack, field extremes, both dump orders at reset capacity
    queue_op(OP_POP, VAL_ONES);
    queue_op(OP_DUMP_DOWN, '0);
    queue_op(OP_DUMP_UP, VAL_MAX);
    queue_op(OP_PUSH, VAL_MIN);
    queue_op(OP_PUSH, VAL_MAX);
    queue_op(OP_PUSH, '0);
    queue_op(OP_PUSH, VAL_ONES);
    queue_op(OP_PUSH, 32'd1);
    queue_op(OP_DUMP_DOWN, '0);
    queue_op(OP_DUMP_UP, '0);
    queue_op(OP_POP, '0);
    queue_op(OP_DUMP_DOWN, VAL_MIN);
    wait_drained();

    // capacity lowered below the fill level: entries stay, pushes drop
    write_capacity(7'd2);
    queue_op(OP_PUSH, 32'd5);
    queue_op(OP_DUMP_UP, '0);
    queue_op(OP_POP, '0);
    queue_op(OP_POP, '0);
    queue_op(OP_PUSH, 32'd7);
    queue_op(OP_POP, '0);
    queue_op(OP_PUSH, 32'd9);
    queue_op(OP_DUMP_DOWN, '0);
    wait_drained();

    // zero capacity: always full, pops and dumps still work
    write_capacity(7'd0);
    queue_op(OP_PUSH, 32'd11);
    queue_op(OP_DUMP_UP, '0);
    queue_op(OP_POP, '0);
    queue_op(OP_POP, '0);
    queue_op(OP_POP, '0);
    queue_op(OP_PUSH, 32'd13);
    queue_op(OP_DUMP_DOWN, '0);
    wait_drained();

    // capacity above depth saturates; fill to the top under a long output hold
    write_capacity(7'd127);
    send_idle_pct  <= 0;
    recv_stall_pct <= 0;
    long_hold_req  <= 1'b1;
    @(posedge clk);
    long_hold_req  <= 1'b0;
    repeat (FILL_PUSHES) queue_op(OP_PUSH, random_value());
    queue_op(OP_DUMP_DOWN, '0);
    repeat (6) queue_op(OP_PUSH, random_value());
    queue_op(OP_DUMP_UP, '0);
    repeat (10) queue_op(OP_POP, '0);
    queue_op(OP_DUMP_DOWN, '0);
    wait_drained();

    // random phases over the idle and stall mixes
    run_phase(0, 0, 7'd64);
    run_phase(63, 0, 7'd1);
    run_phase(0, 63, CAP_W'($urandom_range(2, DEPTH - 1)));
    run_phase(15, 15, 7'd100);

    repeat (2 * SETTLE_CYCLES) @(posedge clk);
    $display("covered %0d stack ops and %0d dump entries, longest dump %0d entries",
             ops_accepted, entries_seen, longest_dump);
    $display("over %0d capacity writes, idle/stall mixes and a %0d-cycle output hold",
             cap_writes, LONG_HOLD);
    if (err_count == 0 && dump_expect_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/bsd_pkg.sv
rtl/bsd_if.sv
rtl/bsd_ctrl.sv
rtl/bsd_dp.sv
rtl/bounded_stack_with_dump_top.sv
dv/tb_bounded_stack_with_dump_top.sv
